### src/tps_pkg.sv
package tps_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int STORE_DEPTH = 65536;
  localparam int ADDR_W      = 16;
  localparam int SIZE_W      = 9;   // 1..256
  localparam int POS_W       = 8;   // texel index 0..255
  localparam int COORD_W     = 18;  // signed Q1.16
  localparam int FRAC_W      = 16;
  localparam int WGT_W       = 17;  // 0..65536
  localparam int WPROD_W     = 33;  // 0..2^32
  localparam int CPROD_W     = 41;  // byte times weight product
  localparam int TAPS        = 4;
  localparam int CHANS       = 4;

  localparam logic [WGT_W-1:0]  ONE_Q16   = 17'd65536;
  localparam logic [WPROD_W:0]  ROUND_ADD = 34'h0_8000_0000;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef enum logic {
    REG_TEX_WIDTH  = 1'b0,
    REG_TEX_HEIGHT = 1'b1
  } reg_idx_t;

  typedef logic [31:0] texel_t;

  // Control that travels alongside each stage.
  typedef struct packed {
    logic vld;
    op_t  op;
  } stage_ctl_t;

endpackage

### src/texture_point_bilinear_sampler.sv
// Texture sampler over a 64K x RGBA8 texel memory.
// Input channel: a word is accepted on a clock edge with start high and busy low.
//   in_operation = write stores {alpha,blue,green,red} at in_texel_address.
//   in_operation = sample reads at (in_coord_u, in_coord_v), Q1.16 clamped to 0..1,
//   nearest texel or bilinear blend per in_use_bilinear.
// Result channel: out_valid pulses for one cycle with the sampled channels.
//   The receiver cannot stall, so the pipeline never stalls either.
// Config port: cfg_we writes cfg_data to tex_width (index 0) or tex_height (1); the user
//   writes only while no item is in flight, which the block itself does not enforce.
// Throughput: one word per clock. busy is high only during reset.
// Pipeline stages, each registered: clamp, coordinate multiply, floor/frac
//   split, address multiply and weight products, texel read, channel products,
//   sum and round.
// The four taps read four copies of the texel memory; each write updates all
// copies at the read stage, so a sample sees every write accepted before it.
// Reset clears stage valid bits and sets both sizes to 256. Memory content is
// undefined until written.
module texture_point_bilinear_sampler (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_operation,
  input  logic [tps_pkg::ADDR_W-1:0]   in_texel_address,
  input  logic [7:0]                   in_red,
  input  logic [7:0]                   in_green,
  input  logic [7:0]                   in_blue,
  input  logic [7:0]                   in_alpha,
  input  logic signed [tps_pkg::COORD_W-1:0] in_coord_u,
  input  logic signed [tps_pkg::COORD_W-1:0] in_coord_v,
  input  logic                         in_use_bilinear,
  output logic                         out_valid,
  output logic [7:0]                   out_red,
  output logic [7:0]                   out_green,
  output logic [7:0]                   out_blue,
  output logic [7:0]                   out_alpha,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [tps_pkg::SIZE_W-1:0]   cfg_data
);
  import tps_pkg::*;

  logic [SIZE_W-1:0] tex_width_r, tex_height_r;
  logic [SIZE_W-1:0] w_sat, h_sat;
  logic [POS_W-1:0]  wm1, hm1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r  <= SIZE_W'(MAX_WIDTH);
      tex_height_r <= SIZE_W'(MAX_HEIGHT);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_TEX_WIDTH:  tex_width_r  <= cfg_data;
        REG_TEX_HEIGHT: tex_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_sat = tex_width_r;
    if (tex_width_r == '0) w_sat = SIZE_W'(1);
    else if (tex_width_r > SIZE_W'(MAX_WIDTH)) w_sat = SIZE_W'(MAX_WIDTH);
    h_sat = tex_height_r;
    if (tex_height_r == '0) h_sat = SIZE_W'(1);
    else if (tex_height_r > SIZE_W'(MAX_HEIGHT)) h_sat = SIZE_W'(MAX_HEIGHT);
    wm1 = POS_W'(w_sat - SIZE_W'(1));
    hm1 = POS_W'(h_sat - SIZE_W'(1));
  end

  assign busy = ~rst_n;

  logic accept;
  assign accept = start & ~busy;

  function automatic logic [WGT_W-1:0] clamp_coord(input logic [COORD_W-1:0] raw);
    logic [WGT_W-1:0] r;
    r = raw[WGT_W-1:0];
    if (raw[COORD_W-1])     r = '0;
    else if (r > ONE_Q16)   r = ONE_Q16;
    return r;
  endfunction

  // stage valid/op
  stage_ctl_t s1_r, s2_r, s3_r, s4_r, s5_r, s6_r;

  // write word carried down to the memory stage
  logic [ADDR_W-1:0] wa1_r, wa2_r, wa3_r, wa4_r;
  texel_t            wd1_r, wd2_r, wd3_r, wd4_r;

  // stage 1
  logic [WGT_W-1:0] cu1_r, cv1_r;
  logic             bil1_r, bil2_r;
  // stage 2
  logic [23:0]      px2_r, py2_r;
  // stage 3
  logic [POS_W-1:0]  x03_r, x13_r, y03_r, y13_r;
  logic [FRAC_W-1:0] fx3_r, fy3_r;
  // stage 4
  logic [ADDR_W-1:0]  ra4_r [TAPS];
  logic [WPROD_W-1:0] wt4_r [TAPS];
  // stage 5
  texel_t             rd5_r [TAPS];
  logic [WPROD_W-1:0] wt5_r [TAPS];
  // stage 6
  logic [CPROD_W-1:0] pr6_r [CHANS][TAPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0; s2_r.vld <= 1'b0; s3_r.vld <= 1'b0;
      s4_r.vld <= 1'b0; s5_r.vld <= 1'b0; s6_r.vld <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_r.vld  <= accept;
      s2_r.vld  <= s1_r.vld;
      s3_r.vld  <= s2_r.vld;
      s4_r.vld  <= s3_r.vld;
      s5_r.vld  <= s4_r.vld & (s4_r.op == OP_SAMPLE);
      s6_r.vld  <= s5_r.vld;
      out_valid <= s6_r.vld;
    end
    s1_r.op <= op_t'(in_operation);
    s2_r.op <= s1_r.op;
    s3_r.op <= s2_r.op;
    s4_r.op <= s3_r.op;
    s5_r.op <= s4_r.op;
    s6_r.op <= s5_r.op;
  end

  // stage 1: capture and clamp
  always_ff @(posedge clk) begin
    wa1_r  <= in_texel_address;
    wd1_r  <= {in_alpha, in_blue, in_green, in_red};
    cu1_r  <= clamp_coord(in_coord_u);
    cv1_r  <= clamp_coord(in_coord_v);
    bil1_r <= in_use_bilinear;
  end

  // stage 2: scale to texel position, Q8.16
  always_ff @(posedge clk) begin
    wa2_r  <= wa1_r;
    wd2_r  <= wd1_r;
    bil2_r <= bil1_r;
    px2_r  <= 24'(cu1_r * wm1);
    py2_r  <= 24'(cv1_r * hm1);
  end

  // stage 3: integer/fraction split; point mode is a blend with zero fraction
  logic [23:0] pxr, pyr;
  always_comb begin
    pxr = px2_r + 24'd32768;
    pyr = py2_r + 24'd32768;
  end

  always_ff @(posedge clk) begin
    wa3_r <= wa2_r;
    wd3_r <= wd2_r;
    if (bil2_r) begin
      x03_r <= px2_r[23:16];
      y03_r <= py2_r[23:16];
      x13_r <= px2_r[23:16] + POS_W'(|px2_r[15:0]);
      y13_r <= py2_r[23:16] + POS_W'(|py2_r[15:0]);
      fx3_r <= px2_r[15:0];
      fy3_r <= py2_r[15:0];
    end else begin
      x03_r <= pxr[23:16];
      y03_r <= pyr[23:16];
      x13_r <= pxr[23:16];
      y13_r <= pyr[23:16];
      fx3_r <= '0;
      fy3_r <= '0;
    end
  end

  // stage 4: linear addresses and tap weights
  // tap order: 00, 10, 01, 11
  logic [ADDR_W:0]  row0, row1;
  logic [WGT_W-1:0] wx0, wx1, wy0, wy1;
  always_comb begin
    row0 = (ADDR_W+1)'(y03_r * w_sat);
    row1 = (ADDR_W+1)'(y13_r * w_sat);
    wx0  = ONE_Q16 - WGT_W'(fx3_r);
    wx1  = WGT_W'(fx3_r);
    wy0  = ONE_Q16 - WGT_W'(fy3_r);
    wy1  = WGT_W'(fy3_r);
  end

  always_ff @(posedge clk) begin
    wa4_r    <= wa3_r;
    wd4_r    <= wd3_r;
    ra4_r[0] <= ADDR_W'(row0 + (ADDR_W+1)'(x03_r));
    ra4_r[1] <= ADDR_W'(row0 + (ADDR_W+1)'(x13_r));
    ra4_r[2] <= ADDR_W'(row1 + (ADDR_W+1)'(x03_r));
    ra4_r[3] <= ADDR_W'(row1 + (ADDR_W+1)'(x13_r));
    wt4_r[0] <= WPROD_W'(wx0 * wy0);
    wt4_r[1] <= WPROD_W'(wx1 * wy0);
    wt4_r[2] <= WPROD_W'(wx0 * wy1);
    wt4_r[3] <= WPROD_W'(wx1 * wy1);
  end

  // stage 5: one memory copy per tap, all written together
  logic mem_we;
  assign mem_we = s4_r.vld & (s4_r.op == OP_WRITE);

  for (genvar g = 0; g < TAPS; g++) begin : g_bank
    texel_t bank [STORE_DEPTH];
    always_ff @(posedge clk) begin
      if (mem_we) begin
        bank[wa4_r] <= wd4_r;
      end else begin
        rd5_r[g] <= bank[ra4_r[g]];
      end
    end
  end

  always_ff @(posedge clk) begin
    wt5_r <= wt4_r;
  end

  // stage 6: byte times weight, one lane per channel and tap
  always_ff @(posedge clk) begin
    for (int c = 0; c < CHANS; c++) begin
      for (int t = 0; t < TAPS; t++) begin
        pr6_r[c][t] <= CPROD_W'(rd5_r[t][8*c +: 8] * wt5_r[t]);
      end
    end
  end

  // output: sum, round half up, keep the byte
  logic [CPROD_W+1:0] acc [CHANS];
  always_comb begin
    for (int c = 0; c < CHANS; c++) begin
      acc[c] = (CPROD_W+2)'(pr6_r[c][0]) + (CPROD_W+2)'(pr6_r[c][1])
             + (CPROD_W+2)'(pr6_r[c][2]) + (CPROD_W+2)'(pr6_r[c][3])
             + (CPROD_W+2)'(ROUND_ADD);
    end
  end

  always_ff @(posedge clk) begin
    out_red   <= acc[0][39:32];
    out_green <= acc[1][39:32];
    out_blue  <= acc[2][39:32];
    out_alpha <= acc[3][39:32];
  end

endmodule

### src/tps_checker.sv
module tps_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_operation,
  input logic out_valid
);
  import tps_pkg::*;

  logic acc_smp, acc_wr;
  assign acc_smp = start && !busy && (in_operation == OP_SAMPLE);
  assign acc_wr  = start && !busy && (in_operation == OP_WRITE);

  a_smp_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc_smp |-> ##7 out_valid)
    else $error("sample word produced no result");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc_smp, 7))
    else $error("result without a sample accepted 7 cycles before");

  a_wr_silent: assert property (@(posedge clk) disable iff (!rst_n)
    acc_wr |-> ##7 !out_valid)
    else $error("write word produced a result");

  a_no_busy: assert property (@(posedge clk)
    rst_n |-> !busy)
    else $error("busy outside reset");

endmodule

bind texture_point_bilinear_sampler tps_checker u_tps_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .in_operation(in_operation), .out_valid(out_valid)
);

### verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tps_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int LATENCY    = 7;

  logic clk, rst_n, start, busy;
  logic in_operation;
  logic [ADDR_W-1:0] in_texel_address;
  logic [7:0] in_red, in_green, in_blue, in_alpha;
  logic signed [COORD_W-1:0] in_coord_u, in_coord_v;
  logic in_use_bilinear;
  logic out_valid;
  logic [7:0] out_red, out_green, out_blue, out_alpha;
  logic cfg_we;
  logic cfg_index;
  logic [SIZE_W-1:0] cfg_data;

  texture_point_bilinear_sampler dut (.*);

  typedef struct {
    op_t op;
    logic [15:0] addr;
    logic [31:0] rgba;
    logic [17:0] u, v;
    logic bil;
    logic chk;          // typed-in color is checked too
    logic [31:0] want;
  } stim_word_t;

  // shadow state of the sampler
  texel_t texels[int];
  int unsigned width_sh, height_sh;
  texel_t color_q[$];
  int errors, idle_cycles;
  bit burst_mode;
  stim_word_t table_rows[$];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string what, input texel_t got, input texel_t want);
    errors++;
    $display("MISMATCH %s: got %08h want %08h at %0t", what, got, want, $realtime);
  endtask

  function automatic int unsigned clamp_q16(input logic [17:0] raw);
    if (raw[17]) return 0;
    if (raw > 18'd65536) return 65536;
    return raw;
  endfunction

  function automatic texel_t texel_at(input int unsigned x, input int unsigned y);
    int unsigned a;
    a = (y * width_sh + x) & 16'hFFFF;
    return texels.exists(a) ? texels[a] : '0;
  endfunction

  function automatic texel_t sample_color(input logic [17:0] u, input logic [17:0] v,
                                          input logic bil);
    int unsigned px, py, x0, y0, x1, y1, fx, fy;
    longint unsigned wx0, wx1, wy0, wy1, acc;
    texel_t t00, t10, t01, t11, res;
    px = clamp_q16(u) * (width_sh - 1);
    py = clamp_q16(v) * (height_sh - 1);
    if (!bil) return texel_at((px + 32768) >> 16, (py + 32768) >> 16);
    x0 = px >> 16; fx = px & 16'hFFFF;
    y0 = py >> 16; fy = py & 16'hFFFF;
    x1 = x0 + (fx != 0); y1 = y0 + (fy != 0);
    wx0 = 65536 - fx; wx1 = fx; wy0 = 65536 - fy; wy1 = fy;
    t00 = texel_at(x0, y0); t10 = texel_at(x1, y0);
    t01 = texel_at(x0, y1); t11 = texel_at(x1, y1);
    for (int c = 0; c < 4; c++) begin
      acc = t00[8*c +: 8] * wx0 * wy0 + t10[8*c +: 8] * wx1 * wy0
          + t01[8*c +: 8] * wx0 * wy1 + t11[8*c +: 8] * wx1 * wy1;
      res[8*c +: 8] = 8'((acc + 64'h8000_0000) >> 32);
    end
    return res;
  endfunction

  function automatic int unsigned sat_size(input int unsigned s);
    return s < 1 ? 1 : (s > 256 ? 256 : s);
  endfunction

  // one word through the input port; idles at random unless in a burst
  task automatic send(input stim_word_t w);
    while (!burst_mode && $urandom_range(99) < 8) begin
      start <= 0;
      @(negedge clk);
    end
    start <= 1;
    in_operation <= w.op;
    in_texel_address <= w.addr;
    {in_alpha, in_blue, in_green, in_red} <= w.rgba;
    in_coord_u <= w.u;
    in_coord_v <= w.v;
    in_use_bilinear <= w.bil;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (w.op == OP_WRITE) texels[w.addr] = w.rgba;
    else begin
      texel_t c;
      c = sample_color(w.u, w.v, w.bil);
      if (w.chk && c !== w.want) report("typed color", c, w.want);
      color_q.push_back(c);
    end
    @(negedge clk);
  endtask

  task automatic drain;
    start <= 0;
    @(negedge clk);
    while (color_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic set_size(input reg_idx_t idx, input int unsigned val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= SIZE_W'(val);
    @(negedge clk);
    cfg_we <= 0;
    if (idx == REG_TEX_WIDTH) width_sh = sat_size(val & 9'h1FF);
    else height_sh = sat_size(val & 9'h1FF);
  endtask

  function automatic stim_word_t wr(input int unsigned a, input texel_t c);
    stim_word_t w;
    w = '{op: OP_WRITE, addr: 16'(a), rgba: c, u: 18'($urandom), v: 18'($urandom),
          bil: 1'($urandom), chk: 1'b0, want: '0};
    return w;
  endfunction

  function automatic stim_word_t smp(input logic [17:0] u, input logic [17:0] v,
                                     input logic b, input logic chk, input texel_t want);
    stim_word_t w;
    w = '{op: OP_SAMPLE, addr: 16'($urandom), rgba: $urandom, u: u, v: v, bil: b,
          chk: chk, want: want};
    return w;
  endfunction

  // write every texel of the w*h texture that holds nothing yet, so no read is
  // of an unwritten entry; earlier writes stay valid across size changes
  task automatic fill_texture;
    for (int a = 0; a < width_sh * height_sh; a++)
      if (!texels.exists(a)) send(wr(a, $urandom));
  endtask

  task automatic random_samples(input int n);
    for (int i = 0; i < n; i++) begin
      logic [17:0] u, v;
      int r;
      r = $urandom_range(9);
      u = r == 0 ? 18'($urandom) : (r == 1 ? 18'h10000 : 18'($urandom_range(65536)));
      r = $urandom_range(9);
      v = r == 0 ? 18'($urandom) : (r == 1 ? 18'h0 : 18'($urandom_range(65536)));
      if ($urandom_range(9) == 0)
        send(wr($urandom_range(width_sh * height_sh - 1), $urandom));
      else
        send(smp(u, v, 1'($urandom), 1'b0, '0));
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (color_q.size() == 0) report("unexpected word", {out_alpha, out_blue,
                                                           out_green, out_red}, 0);
      else begin
        texel_t e;
        e = color_q.pop_front();
        if (out_red !== e[7:0]) report("red", out_red, e[7:0]);
        if (out_green !== e[15:8]) report("green", out_green, e[15:8]);
        if (out_blue !== e[23:16]) report("blue", out_blue, e[23:16]);
        if (out_alpha !== e[31:24]) report("alpha", out_alpha, e[31:24]);
      end
    end
  end

  // watchdog on cycles without any accepted word or result
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) idle_cycles = 0;
    else if (++idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 0; start = 0; cfg_we = 0; cfg_index = 0; cfg_data = 0;
    in_operation = 0; in_texel_address = 0; {in_red, in_green, in_blue, in_alpha} = 0;
    in_coord_u = 0; in_coord_v = 0; in_use_bilinear = 0;
    errors = 0; idle_cycles = 0; burst_mode = 0;
    width_sh = 256; height_sh = 256;
    repeat (12) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // directed: reset sizes 256x256, corners and rounding near the origin
    table_rows = {
      wr(0, 32'h0000_0000), wr(255, 32'hFFFF_FFFF), wr(65280, 32'h8040_2010),
      wr(65535, 32'h01FF_80FE), wr(1, 32'hFFFF_FFFF), wr(256, 32'hFFFF_FFFF),
      wr(257, 32'hFFFF_FFFF),
      smp(18'h0, 18'h0, 0, 1, 32'h0000_0000),
      smp(18'h20000, 18'h3FFFF, 1, 1, 32'h0000_0000),     // negative clamps to 0
      smp(18'h10000, 18'h0, 0, 1, 32'hFFFF_FFFF),
      smp(18'h1FFFF, 18'h0, 1, 1, 32'hFFFF_FFFF),         // above one clamps
      smp(18'h0, 18'h10000, 0, 1, 32'h8040_2010),
      smp(18'h10000, 18'h10000, 1, 1, 32'h01FF_80FE),
      smp(18'h0, 18'h0, 1, 1, 32'h0000_0000),
      smp(18'h80, 18'h0, 0, 0, 0),                        // just under half a texel
      smp(18'h81, 18'h0, 0, 0, 0),                        // just over, rounds up
      smp(18'h80, 18'h80, 1, 0, 0),
      smp(18'h7F, 18'h80, 1, 0, 0)
    };
    foreach (table_rows[i]) send(table_rows[i]);
    drain();

    // several sizes, extremes included; size 0 and oversize saturate
    for (int ph = 0; ph < 7; ph++) begin
      int unsigned ws, hs;
      case (ph)
        0: begin ws = 1; hs = 1; end
        1: begin ws = 0; hs = 300; end
        2: begin ws = 256; hs = 2; end
        3: begin ws = 2; hs = 256; end
        4: begin ws = 511; hs = 0; end
        default: begin ws = $urandom_range(2, 16); hs = $urandom_range(2, 16); end
      endcase
      if (hs == 300) hs = 9'h1FF;
      set_size(REG_TEX_WIDTH, ws);
      set_size(REG_TEX_HEIGHT, hs);
      fill_texture();
      burst_mode = (ph == 5);
      random_samples(ph == 5 ? 60 : 25);
      burst_mode = 0;
      drain();
    end

    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
